/* rtl/core/tksi_pkg.sv */
// types and constants shared by the top-k score insert unit
package tksi_pkg;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 3;
  localparam int SCORE_W  = 20;
  localparam int RANK_W   = 4;
  localparam int SLOT_NUM = 2 ** SLOT_W;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;

  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(999999);

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  typedef logic [SCORE_W-1:0] score_t;

  typedef struct packed {
    logic   ins;
    logic   load;
    score_t score;
  } cell_ctrl_t;

endpackage

/* rtl/core/top_k_score_insert_unit.sv */
// top level of the top-k score insert unit: cell row, rank register and output stage
//
// keeps the best RANK_ENTRIES scores in descending order, slot 0 best.
// input words carry opcode, slot and score: insert, load entry at slot,
// or read entry at slot. every input word yields exactly one output word
// with accepted, rank of the latest accepted insert, and read value.
// a row of cells compares all entries with the score combinationally and
// shifts the lower ones down, so each word finishes in the cycle it is
// taken; its result is registered and appears on out_* in the cycle
// after acceptance. throughput is one word per cycle while the receiver
// does not stall, set by the combinational cell row and the one output register.
// when the receiver stalls, the output word holds and in_tready drops
// until it is taken; a new word is taken in the same cycle the pending
// one leaves.
// reset clears every entry to zero and sets rank to RANK_ENTRIES (none),
// masked to four bits.
module top_k_score_insert_unit #(
  parameter int RANK_ENTRIES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tksi_pkg::IN_W-1:0] in_tdata,   // opcode, slot, score, zero pad
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [tksi_pkg::OUT_W-1:0] out_tdata  // accepted, rank, read_value, zero pad
);
  import tksi_pkg::*;

  localparam int CNT_W = $clog2(RANK_ENTRIES);
  localparam logic [RANK_W-1:0] RANK_NONE = RANK_W'(RANK_ENTRIES);

  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0]   slot;
  logic [SCORE_W-1:0]  score_raw;
  score_t              score;
  logic                in_fire;

  cell_ctrl_t          ctrl;
  score_t              vals  [RANK_ENTRIES];
  logic [RANK_ENTRIES:0] found;
  logic [RANK_ENTRIES-1:0] gt;
  logic                room;

  logic [CNT_W-1:0]    greater;
  score_t              rd_val;
  logic                acc;

  logic [RANK_W-1:0]   rank_r;
  logic [RANK_W-1:0]   rank_nxt;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    out_data_nxt;

  assign opcode    = in_tdata[OPCODE_W-1:0];
  assign slot      = in_tdata[OPCODE_W +: SLOT_W];
  assign score_raw = in_tdata[OPCODE_W+SLOT_W +: SCORE_W];
  assign score     = (score_raw > SCORE_MAX) ? SCORE_MAX : score_raw;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign found[0]  = 1'b0;
  // room only when the last entry is strictly below the score
  assign room      = found[RANK_ENTRIES] && !gt[RANK_ENTRIES-1] &&
                     (vals[RANK_ENTRIES-1] != score);

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.score = score;
    if (in_fire) begin
      unique case (opcode)
        OP_INSERT: ctrl.ins  = room;
        OP_LOAD:   ctrl.load = 1'b1;
        default:   ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < RANK_ENTRIES; g++) begin : g_cell
      logic   load_sel;
      score_t prev_val;
      assign load_sel = (g < SLOT_NUM) && (slot == SLOT_W'(g));
      if (g == 0) begin : g_head
        assign prev_val = '0;
      end else begin : g_body
        assign prev_val = vals[g-1];
      end
      tksi_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_sel  (load_sel),
        .prev_val  (prev_val),
        .found_in  (found[g]),
        .val       (vals[g]),
        .found_out (found[g+1]),
        .gt        (gt[g])
      );
    end
  endgenerate

  always_comb begin
    greater = '0;
    for (int i = 0; i < RANK_ENTRIES - 1; i++) begin
      greater = greater + CNT_W'(gt[i]);
    end
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RANK_ENTRIES; i++) begin
      if (i < SLOT_NUM && slot == SLOT_W'(i)) begin
        rd_val = vals[i];
      end
    end
  end

  always_comb begin
    acc      = 1'b0;
    rank_nxt = rank_r;
    out_data_nxt = '0;
    unique case (opcode)
      OP_INSERT: begin
        acc = room;
        if (room) begin
          rank_nxt = RANK_W'(greater);
        end
      end
      OP_READ: begin
        out_data_nxt[1+RANK_W +: SCORE_W] = rd_val;
      end
      default: ;
    endcase
    out_data_nxt[0]          = acc;
    out_data_nxt[1 +: RANK_W] = rank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r      <= RANK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        rank_r      <= rank_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted word produced no output word");

  a_rank_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && opcode != OP_INSERT) |=> (rank_r == $past(rank_r)))
    else $error("rank changed on a non-insert word");

  a_acc_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[1+RANK_W +: SCORE_W] == '0))
    else $error("accepted insert carries a read value");

  a_reject_keeps_top: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && opcode == OP_INSERT && !room) |=> (vals[0] == $past(vals[0])))
    else $error("rejected insert changed the table");

endmodule

/* rtl/core/tksi_cell.sv */
// one table entry: compares against the incoming score and shifts from its upper neighbor
module tksi_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tksi_pkg::cell_ctrl_t ctrl,
  input  logic                load_sel,
  input  tksi_pkg::score_t    prev_val,
  input  logic                found_in,
  output tksi_pkg::score_t    val,
  output logic                found_out,
  output logic                gt
);
  import tksi_pkg::*;

  score_t val_r;
  score_t val_nxt;
  logic   lt;

  assign lt        = val_r < ctrl.score;
  assign gt        = val_r > ctrl.score;
  assign found_out = found_in | lt;
  assign val       = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (found_in) begin
        val_nxt = prev_val;
      end else if (lt) begin
        val_nxt = ctrl.score;
      end
    end else if (ctrl.load && load_sel) begin
      val_nxt = ctrl.score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// self-checking stream testbench for the top-k score insert unit with its own table predictor
module testbench;
  import tksi_pkg::*;

  localparam int TBL_N = 8;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1300;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [SLOT_W-1:0]   slot;
    logic [SCORE_W-1:0]  score;
  } score_op_t;

  typedef struct {
    logic              accepted;
    logic [RANK_W-1:0] rank;
    score_t            read_value;
  } rank_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;

  // predictor state
  score_t            score_tbl[TBL_N] = '{default: '0};
  logic [RANK_W-1:0] best_rank = RANK_W'(TBL_N);

  score_op_t  score_ops_q[$];
  rank_word_t expected_words[$];

  int  errors = 0;
  int  queued = 0;
  int  src_pct = 0;
  int  sink_pct = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_reqs = 0;
  int  holds_started = 0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  int  n_words = 0;
  int  n_ins = 0;
  int  n_taken = 0;
  int  n_load = 0;
  int  n_read = 0;
  int  n_unused = 0;
  logic in_hs = 1'b0;

  always #1 clk = ~clk;

  top_k_score_insert_unit #(
    .RANK_ENTRIES(TBL_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic score_t limit_score(logic [SCORE_W-1:0] raw);
    return (raw > SCORE_MAX) ? SCORE_MAX : raw;
  endfunction

  task automatic apply_score_op(input score_op_t w, output rank_word_t r);
    score_t s;
    int     pos;
    int     greater;
    int     i;
    s = limit_score(w.score);
    r.accepted = 1'b0;
    r.read_value = '0;
    pos = 0;
    greater = 0;
    case (w.op)
      OP_INSERT: begin
        if (s > score_tbl[TBL_N-1]) begin
          while (pos < TBL_N - 1 && score_tbl[pos] >= s) pos++;
          for (i = 0; i < TBL_N - 1; i++) if (score_tbl[i] > s) greater++;
          for (i = TBL_N - 1; i > pos; i--) score_tbl[i] = score_tbl[i-1];
          score_tbl[pos] = s;
          best_rank = RANK_W'(greater);
          r.accepted = 1'b1;
        end
      end
      OP_LOAD: begin
        if (int'(w.slot) < TBL_N) score_tbl[w.slot] = s;
      end
      OP_READ: begin
        if (int'(w.slot) < TBL_N) r.read_value = score_tbl[w.slot];
      end
      default: ;
    endcase
    r.rank = best_rank;
  endtask

  task automatic report(string what, int unsigned exp_v, int unsigned got_v);
    $display("mismatch in %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic int rand_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_op(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
                        logic [SCORE_W-1:0] score);
    score_op_t w;
    w.op = op;
    w.slot = slot;
    w.score = score;
    score_ops_q.push_back(w);
    queued++;
  endtask

  function automatic logic [SCORE_W-1:0] rand_score(int kind);
    case (kind)
      0: return SCORE_W'($urandom_range(0, 7));
      1: return SCORE_W'($urandom_range(0, 999999));
      2: return SCORE_W'($urandom_range(999990, 2 ** SCORE_W - 1));
      default: return SCORE_W'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic add_sequence();
    int     pick;
    int     kind;
    int     n;
    int     i;
    int     step;
    score_t v;
    pick = $urandom_range(99);
    kind = $urandom_range(3);
    if (pick < 55) begin
      // insert run with occasional reads
      n = $urandom_range(6, 20);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) add_op(OP_READ, SLOT_W'($urandom_range(7)), rand_score(1));
        else add_op(OP_INSERT, SLOT_W'($urandom_range(7)), rand_score(kind));
      end
    end else if (pick < 70) begin
      // load a descending table, sometimes all zero
      v = ($urandom_range(3) == 0) ? score_t'(0) : limit_score(rand_score(kind));
      for (i = 0; i < TBL_N; i++) begin
        add_op(OP_LOAD, SLOT_W'(i), v);
        step = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 99);
        v = (v > score_t'(step)) ? v - score_t'(step) : score_t'(0);
      end
    end else if (pick < 80) begin
      for (i = 0; i < TBL_N; i++) add_op(OP_READ, SLOT_W'(i), rand_score(1));
    end else begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++)
        add_op(OPCODE_W'($urandom_range(3)), SLOT_W'($urandom_range(7)),
               SCORE_W'($urandom_range(0, 2 ** SCORE_W - 1)));
    end
  endtask

  task automatic drain();
    while (score_ops_q.size() > 0 || in_tvalid || expected_words.size() > 0) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_hs) begin
        if (src_gap > 0) begin
          in_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (score_ops_q.size() > 0) begin
          in_tdata <= IN_W'({score_ops_q[0].score, score_ops_q[0].slot, score_ops_q[0].op});
          void'(score_ops_q.pop_front());
          in_tvalid <= 1'b1;
          src_gap <= rand_gap(src_pct);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (holds_started != hold_reqs) begin
        holds_started <= holds_started + 1;
        hold_cnt <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        out_tready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        out_tready <= 1'b1;
        sink_gap <= rand_gap(sink_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : monitor
    score_op_t  w;
    rank_word_t r;
    rank_word_t e;
    if (!rst_n) begin
      in_hs <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_hs <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected output word", 0, out_tdata);
        end else begin
          e = expected_words.pop_front();
          if (out_tdata[0] !== e.accepted) report("accepted", e.accepted, out_tdata[0]);
          if (out_tdata[4:1] !== e.rank) report("rank", e.rank, out_tdata[4:1]);
          if (out_tdata[24:5] !== e.read_value) report("read_value", e.read_value, out_tdata[24:5]);
          if (out_tdata[OUT_W-1:25] !== '0) report("pad bits", 0, out_tdata[OUT_W-1:25]);
        end
      end
      if (in_tvalid && in_tready) begin
        w.op = in_tdata[1:0];
        w.slot = in_tdata[4:2];
        w.score = in_tdata[24:5];
        apply_score_op(w, r);
        expected_words.push_back(r);
        n_words++;
        case (w.op)
          OP_INSERT: begin
            n_ins++;
            if (r.accepted) n_taken++;
          end
          OP_LOAD: n_load++;
          OP_READ: n_read++;
          default: n_unused++;
        endcase
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (score_ops_q.size() > 0 || in_tvalid || expected_words.size() > 0) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    add_op(OP_READ, 3'd0, '0);
    add_op(OP_INSERT, 3'd0, '0);
    add_op(OP_INSERT, 3'd7, SCORE_MAX);
    add_op(OP_INSERT, 3'd0, '1);
    add_op(OP_INSERT, 3'd2, 20'd1);
    add_op(OP_UNUSED, 3'd7, '1);
    add_op(OP_LOAD, 3'd7, '1);
    add_op(OP_READ, 3'd7, '0);
    add_op(OP_INSERT, 3'd0, 20'd500000);
    add_op(OP_LOAD, 3'd7, '0);
    add_op(OP_LOAD, 3'd3, 20'd700000);
    add_op(OP_INSERT, 3'd0, 20'd600000);
    for (int i = 0; i < TBL_N; i++) add_op(OP_READ, SLOT_W'(i), '1);
    add_op(OP_LOAD, 3'd0, 20'hAAAAA);
    add_op(OP_LOAD, 3'd1, 20'h55555);
    add_op(OP_INSERT, 3'd5, 20'd1);
    drain();

    // random, with changing idle mix; receiver holds off hard in one phase
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_pct = 0; sink_pct = 0; end
        1: begin src_pct = 40; sink_pct = 30; end
        2: begin src_pct = 20; sink_pct = 60; hold_reqs++; end
        default: begin src_pct = 60; sink_pct = 10; end
      endcase
      while (queued < 25 + (phase + 1) * RANDOM_WORDS / 4) add_sequence();
      while (score_ops_q.size() > 0) @(negedge clk);
    end
    drain();
    repeat (10) @(negedge clk);

    $display("covered %0d words: %0d inserts (%0d taken), %0d loads, %0d reads, %0d unused op",
             n_words, n_ins, n_taken, n_load, n_read, n_unused);
    $display("idle mixes on both sides plus one %0d-cycle receiver hold-off", LONG_HOLD);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tksi_pkg.sv
rtl/core/tksi_cell.sv
rtl/core/top_k_score_insert_unit.sv
dv/testbench.sv
